[sv/ps2ht_pkg.sv]
// ----------------------------------------------------------------------------
// ps2ht_pkg
// types and constants shared by the ps/2 host transceiver modules
// ----------------------------------------------------------------------------
package ps2ht_pkg;

  localparam int unsigned ShortW = 8;
  localparam int unsigned LongW  = 12;
  localparam int unsigned HoldW  = 8;
  localparam int unsigned WaitW  = 12;
  localparam int unsigned BitW   = 4;
  localparam int unsigned ByteW  = 8;

  localparam logic [ShortW-1:0] ShortReset = 8'd12;
  localparam logic [LongW-1:0]  LongReset  = 12'd2400;
  localparam logic [HoldW-1:0]  HoldReset  = 8'd15;
  localparam logic [BitW-1:0]   BitsPerByte = 4'd8;

  typedef enum logic [1:0] {
    CFG_SHORT_WAIT   = 2'd0,
    CFG_LONG_WAIT    = 2'd1,
    CFG_REQUEST_HOLD = 2'd2,
    CFG_NONE         = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_RECEIVE  = 2'd1,
    CMD_SEND     = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    DRV_REL  = 2'd0,
    DRV_HIGH = 2'd1,
    DRV_LOW  = 2'd2
  } drive_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_CLK_TIMEOUT = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_PARITY      = 3'd3,
    ST_BAD_STOP    = 3'd4,
    ST_REL_TIMEOUT = 3'd5
  } status_e;

  typedef enum logic [4:0] {
    PH_IDLE       = 5'd0,
    PH_RX_START_F = 5'd1,
    PH_RX_START_R = 5'd2,
    PH_RX_BIT_F   = 5'd3,
    PH_RX_BIT_R   = 5'd4,
    PH_RX_PAR_F   = 5'd5,
    PH_RX_PAR_R   = 5'd6,
    PH_RX_STOP_F  = 5'd7,
    PH_RX_STOP_R  = 5'd8,
    PH_TX_HOLD    = 5'd9,
    PH_TX_START_F = 5'd10,
    PH_TX_BIT_R   = 5'd11,
    PH_TX_BIT_F   = 5'd12,
    PH_TX_PAR_R   = 5'd13,
    PH_TX_PAR_F   = 5'd14,
    PH_TX_REL_R   = 5'd15,
    PH_TX_ACK_F   = 5'd16,
    PH_TX_ACK_D   = 5'd17
  } phase_e;

  typedef struct packed {
    logic [WaitW-1:0] short_lim;
    logic [WaitW-1:0] long_lim;
    logic [WaitW-1:0] hold_lim;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [ByteW-1:0] send_byte;
    logic             clk_level;
    logic             data_level;
  } item_t;

  typedef struct packed {
    logic [ByteW-1:0] rx_byte;
    status_e          status;
    logic             was_send;
    logic             done;
    logic             busy;
    drive_e           data_drive;
    logic             clk_pull_low;
  } result_t;

endpackage

[sv/ps2_host_transceiver.sv]
// ----------------------------------------------------------------------------
// ps2_host_transceiver
// ps/2 host receive and send sequencer driven by line-sample tick items
// an accepted item is registered, stepped through the state machine, and its result is registered
// throughput: one item per cycle while the output is not stalled by m_axis_tready_i
// reset: phase idle, both lines released, timeouts 12 / 2400, hold 15 ticks
// ----------------------------------------------------------------------------
module ps2_host_transceiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // send_byte, clk_level, data_level
  input  logic [1:0]  s_axis_tuser_i,  // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // clk_pull_low, data_drive, busy_res, status, rx_byte
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,  // done_res
  output logic        m_axis_tuser_o,  // was_send
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  ps2ht_pkg::cfg_t    cfg;
  ps2ht_pkg::item_t   in_q;
  ps2ht_pkg::result_t res, out_q;
  logic               in_valid_q, out_valid_q;
  logic               advance;

  assign cfg_ready_o     = 1'b1;
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || !out_valid_q || m_axis_tready_i;

  ps2ht_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ps2ht_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.cmd        <= s_axis_tuser_i;
      in_q.send_byte  <= s_axis_tdata_i[7:0];
      in_q.clk_level  <= s_axis_tdata_i[8];
      in_q.data_level <= s_axis_tdata_i[9];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.rx_byte, out_q.status, out_q.busy,
                            out_q.data_drive, out_q.clk_pull_low};
  assign m_axis_tlast_o  = out_q.done;
  assign m_axis_tuser_o  = out_q.was_send;

  // a finished transfer leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.done) |-> !out_q.busy)
    else $error("done result reports busy");

  // status only on the item that ends a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.done) |-> (out_q.status == ps2ht_pkg::ST_OK && !out_q.was_send))
    else $error("status or kind without done");

  // received byte only after a successful receive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.rx_byte != '0) |->
      (out_q.done && !out_q.was_send && out_q.status == ps2ht_pkg::ST_OK))
    else $error("rx byte outside a good receive");

  // a result is never dropped while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> out_valid_q)
    else $error("pending result lost");

endmodule

[sv/ps2ht_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ps2ht_cfg_regs
// timeout and hold registers, zero values read back as one tick
// ----------------------------------------------------------------------------
module ps2ht_cfg_regs (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [11:0]          cfg_data_i,
  output ps2ht_pkg::cfg_t      cfg_o
);

  logic [ps2ht_pkg::ShortW-1:0] short_q;
  logic [ps2ht_pkg::LongW-1:0]  long_q;
  logic [ps2ht_pkg::HoldW-1:0]  hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= ps2ht_pkg::ShortReset;
      long_q  <= ps2ht_pkg::LongReset;
      hold_q  <= ps2ht_pkg::HoldReset;
    end else if (cfg_valid_i) begin
      case (ps2ht_pkg::cfg_idx_e'(cfg_index_i))
        ps2ht_pkg::CFG_SHORT_WAIT:   short_q <= cfg_data_i[ps2ht_pkg::ShortW-1:0];
        ps2ht_pkg::CFG_LONG_WAIT:    long_q  <= cfg_data_i[ps2ht_pkg::LongW-1:0];
        ps2ht_pkg::CFG_REQUEST_HOLD: hold_q  <= cfg_data_i[ps2ht_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  // zero limit acts as one tick
  always_comb begin
    cfg_o.short_lim = (short_q == '0) ? 12'd1 : {4'd0, short_q};
    cfg_o.long_lim  = (long_q == '0) ? 12'd1 : long_q;
    cfg_o.hold_lim  = (hold_q == '0) ? 12'd1 : {4'd0, hold_q};
  end

endmodule

[sv/ps2ht_fsm.sv]
// ----------------------------------------------------------------------------
// ps2ht_fsm
// transfer state machine, one item per step, result formed combinationally
// ----------------------------------------------------------------------------
module ps2ht_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  ps2ht_pkg::item_t     item_i,
  input  ps2ht_pkg::cfg_t      cfg_i,
  output ps2ht_pkg::result_t   res_o
);

  ps2ht_pkg::phase_e              phase_q, phase_d;
  logic                           is_send_q, is_send_d;
  logic [ps2ht_pkg::BitW-1:0]     bit_q, bit_d;
  logic [ps2ht_pkg::ByteW-1:0]    shift_q, shift_d;
  logic                           zpar_q, zpar_d;
  logic [ps2ht_pkg::WaitW-1:0]    wait_q, wait_d;
  logic                           clk_drv_q, clk_drv_d;
  ps2ht_pkg::drive_e              dat_drv_q, dat_drv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= ps2ht_pkg::PH_IDLE;
      is_send_q <= 1'b0;
      bit_q     <= '0;
      shift_q   <= '0;
      zpar_q    <= 1'b0;
      wait_q    <= '0;
      clk_drv_q <= 1'b0;
      dat_drv_q <= ps2ht_pkg::DRV_REL;
    end else if (step_i) begin
      phase_q   <= phase_d;
      is_send_q <= is_send_d;
      bit_q     <= bit_d;
      shift_q   <= shift_d;
      zpar_q    <= zpar_d;
      wait_q    <= wait_d;
      clk_drv_q <= clk_drv_d;
      dat_drv_q <= dat_drv_d;
    end
  end

  logic                        done;
  ps2ht_pkg::status_e          st;
  logic                        met;
  logic [ps2ht_pkg::WaitW-1:0] limit;
  logic [ps2ht_pkg::WaitW-1:0] wait_inc;
  logic [ps2ht_pkg::BitW-1:0]  bit_inc;
  logic [ps2ht_pkg::ByteW-1:0] shift_dn;

  always_comb begin
    phase_d   = phase_q;
    is_send_d = is_send_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    zpar_d    = zpar_q;
    wait_d    = wait_q;
    clk_drv_d = clk_drv_q;
    dat_drv_d = dat_drv_q;
    done      = 1'b0;
    st        = ps2ht_pkg::ST_OK;
    wait_inc  = wait_q + 12'd1;
    bit_inc   = bit_q + 4'd1;
    shift_dn  = {1'b0, shift_q[ps2ht_pkg::ByteW-1:1]};
    limit     = cfg_i.short_lim;
    met       = 1'b0;

    if (phase_q == ps2ht_pkg::PH_TX_START_F || phase_q == ps2ht_pkg::PH_RX_START_F) begin
      limit = cfg_i.long_lim;
    end
    case (phase_q)
      ps2ht_pkg::PH_TX_ACK_D: met = item_i.data_level;
      ps2ht_pkg::PH_RX_START_R, ps2ht_pkg::PH_RX_BIT_R, ps2ht_pkg::PH_RX_PAR_R,
      ps2ht_pkg::PH_RX_STOP_R, ps2ht_pkg::PH_TX_BIT_R, ps2ht_pkg::PH_TX_PAR_R,
      ps2ht_pkg::PH_TX_REL_R: met = item_i.clk_level;
      default: met = !item_i.clk_level;
    endcase

    if (phase_q == ps2ht_pkg::PH_IDLE) begin
      if (item_i.cmd == ps2ht_pkg::CMD_RECEIVE || item_i.cmd == ps2ht_pkg::CMD_SEND) begin
        is_send_d = (item_i.cmd == ps2ht_pkg::CMD_SEND);
        bit_d     = '0;
        zpar_d    = 1'b0;
        wait_d    = '0;
        if (item_i.cmd == ps2ht_pkg::CMD_RECEIVE) begin
          shift_d   = '0;
          clk_drv_d = 1'b0;
          dat_drv_d = ps2ht_pkg::DRV_REL;
          phase_d   = ps2ht_pkg::PH_RX_START_F;
        end else begin
          shift_d   = item_i.send_byte;
          clk_drv_d = 1'b1;
          dat_drv_d = ps2ht_pkg::DRV_HIGH;
          phase_d   = ps2ht_pkg::PH_TX_HOLD;
        end
      end
    end else if (item_i.cmd == ps2ht_pkg::CMD_TICK) begin
      if (phase_q == ps2ht_pkg::PH_TX_HOLD) begin
        wait_d = wait_inc;
        if (wait_inc >= cfg_i.hold_lim) begin
          wait_d    = '0;
          dat_drv_d = ps2ht_pkg::DRV_LOW;
          clk_drv_d = 1'b0;
          phase_d   = ps2ht_pkg::PH_TX_START_F;
        end
      end else if (!met) begin
        wait_d = wait_inc;
        if (wait_inc >= limit) begin
          done = 1'b1;
          st   = (phase_q == ps2ht_pkg::PH_TX_ACK_D) ? ps2ht_pkg::ST_REL_TIMEOUT
                                                      : ps2ht_pkg::ST_CLK_TIMEOUT;
        end
      end else begin
        wait_d = '0;
        case (phase_q)
          ps2ht_pkg::PH_RX_START_F: begin
            if (item_i.data_level) begin
              done = 1'b1;
              st   = ps2ht_pkg::ST_BAD_START;
            end else begin
              phase_d = ps2ht_pkg::PH_RX_START_R;
            end
          end
          ps2ht_pkg::PH_RX_START_R: phase_d = ps2ht_pkg::PH_RX_BIT_F;
          ps2ht_pkg::PH_RX_BIT_F: begin
            shift_d = {item_i.data_level, shift_q[ps2ht_pkg::ByteW-1:1]};
            zpar_d  = zpar_q ^ !item_i.data_level;
            phase_d = ps2ht_pkg::PH_RX_BIT_R;
          end
          ps2ht_pkg::PH_RX_BIT_R: begin
            bit_d   = bit_inc;
            phase_d = (bit_inc >= ps2ht_pkg::BitsPerByte) ? ps2ht_pkg::PH_RX_PAR_F
                                                           : ps2ht_pkg::PH_RX_BIT_F;
          end
          ps2ht_pkg::PH_RX_PAR_F: begin
            if (!item_i.data_level != zpar_q) begin
              done = 1'b1;
              st   = ps2ht_pkg::ST_PARITY;
            end else begin
              phase_d = ps2ht_pkg::PH_RX_PAR_R;
            end
          end
          ps2ht_pkg::PH_RX_PAR_R: phase_d = ps2ht_pkg::PH_RX_STOP_F;
          ps2ht_pkg::PH_RX_STOP_F: begin
            if (!item_i.data_level) begin
              done = 1'b1;
              st   = ps2ht_pkg::ST_BAD_STOP;
            end else begin
              phase_d = ps2ht_pkg::PH_RX_STOP_R;
            end
          end
          ps2ht_pkg::PH_RX_STOP_R, ps2ht_pkg::PH_TX_ACK_D: begin
            done      = 1'b1;
            clk_drv_d = 1'b1;
            dat_drv_d = ps2ht_pkg::DRV_HIGH;
          end
          ps2ht_pkg::PH_TX_START_F: begin
            dat_drv_d = shift_q[0] ? ps2ht_pkg::DRV_HIGH : ps2ht_pkg::DRV_LOW;
            zpar_d    = zpar_q ^ !shift_q[0];
            phase_d   = ps2ht_pkg::PH_TX_BIT_R;
          end
          ps2ht_pkg::PH_TX_BIT_R: phase_d = ps2ht_pkg::PH_TX_BIT_F;
          ps2ht_pkg::PH_TX_BIT_F: begin
            bit_d   = bit_inc;
            shift_d = shift_dn;
            if (bit_inc < ps2ht_pkg::BitsPerByte) begin
              dat_drv_d = shift_dn[0] ? ps2ht_pkg::DRV_HIGH : ps2ht_pkg::DRV_LOW;
              zpar_d    = zpar_q ^ !shift_dn[0];
              phase_d   = ps2ht_pkg::PH_TX_BIT_R;
            end else begin
              dat_drv_d = zpar_q ? ps2ht_pkg::DRV_LOW : ps2ht_pkg::DRV_HIGH;
              phase_d   = ps2ht_pkg::PH_TX_PAR_R;
            end
          end
          ps2ht_pkg::PH_TX_PAR_R: phase_d = ps2ht_pkg::PH_TX_PAR_F;
          ps2ht_pkg::PH_TX_PAR_F: begin
            dat_drv_d = ps2ht_pkg::DRV_REL;
            phase_d   = ps2ht_pkg::PH_TX_REL_R;
          end
          ps2ht_pkg::PH_TX_REL_R: phase_d = ps2ht_pkg::PH_TX_ACK_F;
          ps2ht_pkg::PH_TX_ACK_F: phase_d = ps2ht_pkg::PH_TX_ACK_D;
          default: begin
            done = 1'b1;
            st   = ps2ht_pkg::ST_CLK_TIMEOUT;
          end
        endcase
      end
    end

    if (done) begin
      phase_d = ps2ht_pkg::PH_IDLE;
      wait_d  = '0;
    end

    res_o.clk_pull_low = clk_drv_d;
    res_o.data_drive   = dat_drv_d;
    res_o.busy         = (phase_d != ps2ht_pkg::PH_IDLE);
    res_o.done         = done;
    res_o.was_send     = done & is_send_q;
    res_o.status       = st;
    res_o.rx_byte      = (done && st == ps2ht_pkg::ST_OK && !is_send_q) ? shift_q : '0;
  end

endmodule
